// ----- rtl/vpp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpp_pkg
// Shared types and constants of the vertex plane projection core.
// ----------------------------------------------------------------------------
package vpp_pkg;

  // screen size in pixels
  localparam int SCREEN_WIDTH  = 640;
  localparam int SCREEN_HEIGHT = 480;

  // plane offsets in plane units
  localparam int OFFSET_X = 40;
  localparam int OFFSET_Y = 30;

  // configuration port
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 3;

  // divider lane: dividend width, divisor width, latency
  localparam int DIV_NW  = 56;
  localparam int DIV_DW  = 35;
  localparam int DIV_LAT = DIV_NW + 2;

  // integer square root working width
  localparam int ISQ_W = 35;

  typedef enum logic [2:0] {
    REG_EYE,
    REG_NORMAL,
    REG_CENTROID,
    REG_CORNER_A,
    REG_CORNER_B,
    REG_CORNER_D,
    REG_WIDTH,
    REG_HEIGHT
  } cfg_reg_e;

  typedef enum logic [2:0] {
    PREP_IDLE,
    PREP_DIFF,
    PREP_MUL,
    PREP_SUM,
    PREP_ROOT
  } prep_state_e;

  typedef struct packed {
    logic signed [15:0] vertex_x;
    logic signed [15:0] vertex_y;
    logic signed [15:0] vertex_z;
    logic [2:0]         vertex_tag;
  } vpp_in_t;

  typedef struct packed {
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic [2:0]         result_tag;
    logic               ok;
  } vpp_out_t;

  // control that rides along with the data through the pipeline
  typedef struct packed {
    logic       valid;
    logic [2:0] tag;
    logic       ok;
  } vpp_side_t;

  // configuration and values derived from it
  typedef struct packed {
    logic [2:0][15:0] eye;
    logic [2:0][15:0] nrm;
    logic [2:0][16:0] ea;
    logic [2:0][16:0] ab;
    logic [2:0][16:0] ad;
    logic [34:0]      num;
    logic [16:0]      rab;
    logic [16:0]      rad;
    logic             basis_ok;
    logic [11:0]      wid;
    logic [11:0]      hgt;
  } vpp_cfg_t;

endpackage

// ----- rtl/vpp_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpp_div
// Pipelined signed divider, one quotient bit per stage, truncating.
// ----------------------------------------------------------------------------
module vpp_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic signed [vpp_pkg::DIV_NW-1:0]    num_i,
  input  logic signed [vpp_pkg::DIV_DW-1:0]    den_i,
  input  vpp_pkg::vpp_side_t                   side_i,
  output logic signed [vpp_pkg::DIV_NW-1:0]    quo_o,
  output vpp_pkg::vpp_side_t                   side_o
);
  import vpp_pkg::*;

  localparam int REM_W = DIV_DW + 1;

  logic [DIV_NW-1:0] in_num_q;
  logic [DIV_DW-1:0] in_den_q;
  logic              in_neg_q;
  vpp_side_t         in_side_q;

  logic [REM_W-1:0]  rem_q  [DIV_NW];
  logic [DIV_NW-1:0] work_q [DIV_NW];
  logic [DIV_DW-1:0] den_q  [DIV_NW];
  logic              neg_q  [DIV_NW];
  vpp_side_t         side_q [DIV_NW];

  logic [REM_W-1:0]  rem_d  [DIV_NW];
  logic [DIV_NW-1:0] work_d [DIV_NW];

  logic [DIV_NW-1:0] quo_q;
  vpp_side_t         out_side_q;

  // magnitudes and quotient sign
  always_ff @(posedge clk_i) begin
    in_num_q <= num_i[DIV_NW-1] ? DIV_NW'(-num_i) : DIV_NW'(num_i);
    in_den_q <= den_i[DIV_DW-1] ? DIV_DW'(-den_i) : DIV_DW'(den_i);
    in_neg_q <= num_i[DIV_NW-1] ^ den_i[DIV_DW-1];
  end

  // restoring step per stage
  always_comb begin
    logic [REM_W-1:0]  rem_in;
    logic [DIV_NW-1:0] work_in;
    logic [DIV_DW-1:0] den_in;
    logic [REM_W-1:0]  shifted;
    logic              fits;
    for (int i = 0; i < DIV_NW; i++) begin
      if (i == 0) begin
        rem_in  = '0;
        work_in = in_num_q;
        den_in  = in_den_q;
      end else begin
        rem_in  = rem_q[i-1];
        work_in = work_q[i-1];
        den_in  = den_q[i-1];
      end
      shifted   = {rem_in[REM_W-2:0], work_in[DIV_NW-1]};
      fits      = shifted >= {1'b0, den_in};
      rem_d[i]  = fits ? (shifted - {1'b0, den_in}) : shifted;
      work_d[i] = {work_in[DIV_NW-2:0], fits};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DIV_NW; i++) begin
      rem_q[i]  <= rem_d[i];
      work_q[i] <= work_d[i];
      den_q[i]  <= (i == 0) ? in_den_q : den_q[i-1];
      neg_q[i]  <= (i == 0) ? in_neg_q : neg_q[i-1];
    end
    quo_q <= neg_q[DIV_NW-1] ? DIV_NW'(-work_q[DIV_NW-1]) : work_q[DIV_NW-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_side_q  <= '0;
      out_side_q <= '0;
      for (int i = 0; i < DIV_NW; i++) begin
        side_q[i] <= '0;
      end
    end else begin
      in_side_q <= side_i;
      for (int i = 0; i < DIV_NW; i++) begin
        side_q[i] <= (i == 0) ? in_side_q : side_q[i-1];
      end
      out_side_q <= side_q[DIV_NW-1];
    end
  end

  assign quo_o  = $signed(quo_q);
  assign side_o = out_side_q;

endmodule

// ----- rtl/vpp_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpp_cfg
// Configuration registers and the setup sequencer that derives the basis
// axes, their square-root lengths and the plane numerator.
// ----------------------------------------------------------------------------
module vpp_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [vpp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [vpp_pkg::CFG_W-1:0]        cfg_data_i,
  output vpp_pkg::vpp_cfg_t                cfg_o,
  output logic                             busy_o
);
  import vpp_pkg::*;

  localparam logic [ISQ_W-1:0] ISQ_TOP = ISQ_W'(1) << (ISQ_W - 3);

  logic [CFG_W-1:0] eye_q, nrm_q, cen_q, ca_q, cb_q, cd_q;
  logic [11:0]      wid_q, hgt_q;

  prep_state_e state_q, state_d;
  logic        busy, diff_en, mul_en, sum_en, root_en;

  logic signed [16:0] ea_q [3], ab_q [3], ad_q [3], ec_q [3];
  logic [31:0]        sab_q [3], sad_q [3];
  logic signed [32:0] nc_q [3];
  logic signed [34:0] num_q;
  logic               basis_ok_q;
  logic [ISQ_W-1:0]   rs_ab_q, rr_ab_q, rs_ad_q, rr_ad_q, bit_q;
  logic [ISQ_W-1:0]   rs_ab_d, rr_ab_d, rs_ad_d, rr_ad_d;
  logic [ISQ_W-1:0]   sum_ab, sum_ad;

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eye_q <= '0;
      nrm_q <= 48'h0100_0000_0000;
      cen_q <= '0;
      ca_q  <= '0;
      cb_q  <= 48'h0000_0000_0100;
      cd_q  <= 48'h0000_0100_0000;
      wid_q <= 12'd80;
      hgt_q <= 12'd60;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_EYE:      eye_q <= cfg_data_i;
        REG_NORMAL:   nrm_q <= cfg_data_i;
        REG_CENTROID: cen_q <= cfg_data_i;
        REG_CORNER_A: ca_q  <= cfg_data_i;
        REG_CORNER_B: cb_q  <= cfg_data_i;
        REG_CORNER_D: cd_q  <= cfg_data_i;
        REG_WIDTH:    wid_q <= cfg_data_i[11:0];
        REG_HEIGHT:   hgt_q <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // setup sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PREP_DIFF;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    case (state_q)
      PREP_IDLE: state_d = PREP_IDLE;
      PREP_DIFF: state_d = PREP_MUL;
      PREP_MUL:  state_d = PREP_SUM;
      PREP_SUM:  state_d = PREP_ROOT;
      PREP_ROOT: state_d = bit_q[0] ? PREP_IDLE : PREP_ROOT;
      default:   state_d = PREP_IDLE;
    endcase
    if (cfg_we_i) begin
      state_d = PREP_DIFF;
    end
  end

  always_comb begin
    busy    = 1'b1;
    diff_en = 1'b0;
    mul_en  = 1'b0;
    sum_en  = 1'b0;
    root_en = 1'b0;
    case (state_q)
      PREP_IDLE: busy    = 1'b0;
      PREP_DIFF: diff_en = 1'b1;
      PREP_MUL:  mul_en  = 1'b1;
      PREP_SUM:  sum_en  = 1'b1;
      PREP_ROOT: root_en = 1'b1;
      default:   busy    = 1'b0;
    endcase
  end

  // one digit per cycle of the square roots
  always_comb begin
    rs_ab_d = rs_ab_q;
    rr_ab_d = rr_ab_q >> 1;
    if (rs_ab_q >= rr_ab_q + bit_q) begin
      rs_ab_d = rs_ab_q - (rr_ab_q + bit_q);
      rr_ab_d = (rr_ab_q >> 1) + bit_q;
    end
    rs_ad_d = rs_ad_q;
    rr_ad_d = rr_ad_q >> 1;
    if (rs_ad_q >= rr_ad_q + bit_q) begin
      rs_ad_d = rs_ad_q - (rr_ad_q + bit_q);
      rr_ad_d = (rr_ad_q >> 1) + bit_q;
    end
  end

  assign sum_ab = ISQ_W'(sab_q[0]) + ISQ_W'(sab_q[1]) + ISQ_W'(sab_q[2]);
  assign sum_ad = ISQ_W'(sad_q[0]) + ISQ_W'(sad_q[1]) + ISQ_W'(sad_q[2]);

  always_ff @(posedge clk_i) begin
    if (diff_en) begin
      for (int k = 0; k < 3; k++) begin
        ea_q[k] <= 17'($signed(eye_q[16*k +: 16])) - 17'($signed(ca_q[16*k +: 16]));
        ab_q[k] <= 17'($signed(cb_q[16*k +: 16])) - 17'($signed(ca_q[16*k +: 16]));
        ad_q[k] <= 17'($signed(cd_q[16*k +: 16])) - 17'($signed(ca_q[16*k +: 16]));
        ec_q[k] <= 17'($signed(eye_q[16*k +: 16])) - 17'($signed(cen_q[16*k +: 16]));
      end
    end
    if (mul_en) begin
      for (int k = 0; k < 3; k++) begin
        sab_q[k] <= 32'(ab_q[k] * ab_q[k]);
        sad_q[k] <= 32'(ad_q[k] * ad_q[k]);
        nc_q[k]  <= $signed(nrm_q[16*k +: 16]) * ec_q[k];
      end
    end
    if (sum_en) begin
      num_q      <= 35'(nc_q[0]) + 35'(nc_q[1]) + 35'(nc_q[2]);
      basis_ok_q <= (sum_ab != '0) && (sum_ad != '0);
      rs_ab_q    <= sum_ab;
      rs_ad_q    <= sum_ad;
      rr_ab_q    <= '0;
      rr_ad_q    <= '0;
      bit_q      <= ISQ_TOP;
    end else if (root_en) begin
      rs_ab_q <= rs_ab_d;
      rs_ad_q <= rs_ad_d;
      rr_ab_q <= rr_ab_d;
      rr_ad_q <= rr_ad_d;
      bit_q   <= bit_q >> 2;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cfg_o.eye[k] = eye_q[16*k +: 16];
      cfg_o.nrm[k] = nrm_q[16*k +: 16];
      cfg_o.ea[k]  = ea_q[k];
      cfg_o.ab[k]  = ab_q[k];
      cfg_o.ad[k]  = ad_q[k];
    end
    cfg_o.num      = num_q;
    cfg_o.rab      = rr_ab_q[16:0];
    cfg_o.rad      = rr_ad_q[16:0];
    cfg_o.basis_ok = basis_ok_q;
    cfg_o.wid      = (wid_q == '0) ? 12'd1 : wid_q;
    cfg_o.hgt      = (hgt_q == '0) ? 12'd1 : hgt_q;
  end

  assign busy_o = busy | cfg_we_i;

endmodule

// ----- rtl/vertex_plane_projection_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_plane_projection_core
// Projects a vertex through the eye onto a configured plane and maps the hit
// point to saturated screen pixel coordinates.
// ----------------------------------------------------------------------------
// One vertex is taken at every clock edge where start_i is high and busy_o is
// low; the result comes out as a one-cycle strobe on result_valid_o, in order,
// one result per vertex. The receiver cannot hold results off, so the pipeline
// never stalls and takes a vertex every cycle while busy_o is low. The latency
// is set by three 58-stage divider lanes in series (the ray parameter, the
// basis projection and the screen scaling, one quotient bit per stage) plus ten
// stages of multiply, sum and clamp. busy_o is high during a config write,
// after it and after reset, while the setup sequencer recomputes the axes,
// their square-root lengths digit by digit and the plane numerator.
module vertex_plane_projection_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  vpp_pkg::vpp_in_t                 item_i,
  output logic                             result_valid_o,
  output vpp_pkg::vpp_out_t                result_o,
  input  logic                             cfg_we_i,
  input  logic [vpp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [vpp_pkg::CFG_W-1:0]        cfg_data_i
);
  import vpp_pkg::*;

  localparam int V_W = 44;

  // clamp limits
  localparam logic signed [DIV_NW:0] PA_HI = {{(DIV_NW-30){1'b0}}, {31{1'b1}}};
  localparam logic signed [DIV_NW:0] PA_LO = {{(DIV_NW-30){1'b1}}, 31'b0};
  localparam logic signed [DIV_NW-1:0] P_HI = {{(DIV_NW-41){1'b0}}, 1'b1, 40'b0};
  localparam logic signed [DIV_NW-1:0] P_LO = {{(DIV_NW-40){1'b1}}, 40'b0};
  localparam logic signed [DIV_NW-1:0] S_HI = DIV_NW'(32767);
  localparam logic signed [DIV_NW-1:0] S_LO = -(DIV_NW'(32768));

  vpp_cfg_t cfg;
  logic     accept;

  logic signed [15:0] vtx [3];

  // stage 1: ray direction and eye minus vertex
  logic               s1_valid_q;
  logic [2:0]         s1_tag_q;
  logic signed [16:0] s1_dir_q [3];
  logic signed [16:0] s1_edv_q [3];
  // stage 2: normal products
  logic               s2_valid_q;
  logic [2:0]         s2_tag_q;
  logic signed [16:0] s2_dir_q [3];
  logic signed [32:0] s2_dp_q  [3];
  // stage 3: denominator
  logic               s3_valid_q;
  logic [2:0]         s3_tag_q;
  logic signed [16:0] s3_dir_q [3];
  logic signed [34:0] s3_den_q;
  // stage 4: numerator times direction
  vpp_side_t          s4_side_q;
  logic signed [51:0] s4_mul_q [3];
  logic signed [34:0] s4_den_q;

  logic signed [DIV_NW-1:0] off   [3];
  vpp_side_t                off_side [3];

  // stage 5: hit point relative to corner a
  vpp_side_t          s5_side_q;
  logic signed [31:0] s5_pa_q [3];
  logic signed [31:0] pa_d    [3];
  // stage 6: axis products, lane 0 horizontal, lane 1 vertical
  vpp_side_t          s6_side_q;
  logic signed [48:0] s6_pp_q [2][3];
  // stage 7: dot products
  vpp_side_t          s7_side_q;
  logic signed [50:0] s7_dot_q [2];

  logic signed [DIV_NW-1:0] pln   [2];
  vpp_side_t                pln_side [2];
  logic [16:0]              axis_len [2];

  // stage 8: clamp and shift into screen space
  vpp_side_t            s8_side_q;
  logic signed [V_W-1:0] s8_v_q [2];
  logic signed [V_W-1:0] v_d    [2];
  logic [11:0]          ext   [2];
  // stage 9: scale by screen size
  vpp_side_t               s9_side_q;
  logic signed [DIV_NW-1:0] s9_prod_q [2];

  logic signed [DIV_NW-1:0] scr  [2];
  vpp_side_t                scr_side [2];
  logic signed [15:0]       scr_sat [2];

  logic     result_valid_q;
  vpp_out_t result_q;

  vpp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg),
    .busy_o     (busy_o)
  );

  assign accept = start_i & ~busy_o;

  assign vtx[0] = item_i.vertex_x;
  assign vtx[1] = item_i.vertex_y;
  assign vtx[2] = item_i.vertex_z;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_side_q  <= '0;
      s5_side_q  <= '0;
      s6_side_q  <= '0;
      s7_side_q  <= '0;
      s8_side_q  <= '0;
      s9_side_q  <= '0;
      result_valid_q <= 1'b0;
    end else begin
      s1_valid_q      <= accept;
      s2_valid_q      <= s1_valid_q;
      s3_valid_q      <= s2_valid_q;
      s4_side_q.valid <= s3_valid_q;
      s4_side_q.tag   <= s3_tag_q;
      s4_side_q.ok    <= s3_den_q != '0;  // ray not parallel to the plane
      s5_side_q       <= off_side[0];
      s6_side_q       <= s5_side_q;
      s7_side_q       <= s6_side_q;
      s8_side_q       <= pln_side[0];
      s9_side_q       <= s8_side_q;
      result_valid_q  <= scr_side[0].valid;
    end
  end

  // front end: denominator n.(e - v) and num * dir
  always_ff @(posedge clk_i) begin
    s1_tag_q <= item_i.vertex_tag;
    s2_tag_q <= s1_tag_q;
    s3_tag_q <= s2_tag_q;
    for (int k = 0; k < 3; k++) begin
      s1_dir_q[k] <= 17'(vtx[k]) - 17'($signed(cfg.eye[k]));
      s1_edv_q[k] <= 17'($signed(cfg.eye[k])) - 17'(vtx[k]);
      s2_dir_q[k] <= s1_dir_q[k];
      s2_dp_q[k]  <= $signed(cfg.nrm[k]) * s1_edv_q[k];
      s3_dir_q[k] <= s2_dir_q[k];
      s4_mul_q[k] <= $signed(cfg.num) * s3_dir_q[k];
    end
    s3_den_q <= 35'(s2_dp_q[0]) + 35'(s2_dp_q[1]) + 35'(s2_dp_q[2]);
    s4_den_q <= s3_den_q;
  end

  // ray parameter times direction, divided by the denominator, per axis
  for (genvar k = 0; k < 3; k++) begin : g_off
    vpp_div u_div_off (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .num_i  (DIV_NW'(s4_mul_q[k])),
      .den_i  (s4_den_q),
      .side_i (s4_side_q),
      .quo_o  (off[k]),
      .side_o (off_side[k])
    );
  end

  // hit point minus corner a, clamped to 32 bits
  always_comb begin
    logic signed [DIV_NW:0] sum;
    for (int k = 0; k < 3; k++) begin
      sum = (DIV_NW+1)'($signed(cfg.ea[k])) + (DIV_NW+1)'(off[k]);
      if (sum > PA_HI) begin
        pa_d[k] = PA_HI[31:0];
      end else if (sum < PA_LO) begin
        pa_d[k] = PA_LO[31:0];
      end else begin
        pa_d[k] = sum[31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      s5_pa_q[k]    <= pa_d[k];
      s6_pp_q[0][k] <= s5_pa_q[k] * $signed(cfg.ab[k]);
      s6_pp_q[1][k] <= s5_pa_q[k] * $signed(cfg.ad[k]);
    end
    for (int j = 0; j < 2; j++) begin
      s7_dot_q[j] <= 51'(s6_pp_q[j][0]) + 51'(s6_pp_q[j][1]) + 51'(s6_pp_q[j][2]);
    end
  end

  assign axis_len[0] = cfg.rab;
  assign axis_len[1] = cfg.rad;
  assign ext[0]      = cfg.wid;
  assign ext[1]      = cfg.hgt;

  // projection onto the unit axes
  for (genvar j = 0; j < 2; j++) begin : g_pln
    vpp_div u_div_pln (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .num_i  (DIV_NW'(s7_dot_q[j])),
      .den_i  ($signed(DIV_DW'(axis_len[j]))),
      .side_i (s7_side_q),
      .quo_o  (pln[j]),
      .side_o (pln_side[j])
    );
  end

  // clamp, remove the plane offset and recenter: 2*(p - off*256) + ext*256
  always_comb begin
    logic signed [DIV_NW-1:0] p;
    for (int j = 0; j < 2; j++) begin
      if (pln[j] > P_HI) begin
        p = P_HI;
      end else if (pln[j] < P_LO) begin
        p = P_LO;
      end else begin
        p = pln[j];
      end
      v_d[j] = (V_W'(p) <<< 1)
             - V_W'(2 * 256 * ((j == 0) ? OFFSET_X : OFFSET_Y))
             + $signed(V_W'({ext[j], 8'b0}));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 2; j++) begin
      s8_v_q[j] <= v_d[j];
    end
    s9_prod_q[0] <= DIV_NW'(s8_v_q[0]) * DIV_NW'(SCREEN_WIDTH);
    s9_prod_q[1] <= DIV_NW'(s8_v_q[1]) * DIV_NW'(SCREEN_HEIGHT);
  end

  // divide by ext*512 for pixels
  for (genvar j = 0; j < 2; j++) begin : g_scr
    vpp_div u_div_scr (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .num_i  (s9_prod_q[j]),
      .den_i  ($signed(DIV_DW'({ext[j], 9'b0}))),
      .side_i (s9_side_q),
      .quo_o  (scr[j]),
      .side_o (scr_side[j])
    );
  end

  // saturate to 16 bits
  always_comb begin
    for (int j = 0; j < 2; j++) begin
      if (scr[j] > S_HI) begin
        scr_sat[j] = S_HI[15:0];
      end else if (scr[j] < S_LO) begin
        scr_sat[j] = S_LO[15:0];
      end else begin
        scr_sat[j] = scr[j][15:0];
      end
    end
  end

  // result register, zeros when parallel ray or degenerate basis
  always_ff @(posedge clk_i) begin
    result_q.ok         <= scr_side[0].ok & cfg.basis_ok;
    result_q.result_tag <= scr_side[0].tag;
    result_q.screen_x   <= (scr_side[0].ok & cfg.basis_ok) ? scr_sat[0] : '0;
    result_q.screen_y   <= (scr_side[0].ok & cfg.basis_ok) ? scr_sat[1] : '0;
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the vertex plane projection core. Vertices go in
// from a queue of pending items and are checked against a built-in projection
// predictor, in order, under several plane setups and with random idle bursts.
// ----------------------------------------------------------------------------
module testbench;
  import vpp_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 220;   // pipeline latency plus setup time

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  vpp_in_t            item_i = '0;
  logic               result_valid_o;
  vpp_out_t           result_o;
  logic               cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]   cfg_data_i = '0;

  vertex_plane_projection_core uut (
    .clk_i, .rst_ni, .start_i, .busy_o, .item_i, .result_valid_o, .result_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // plane setup as the predictor sees it
  logic [47:0] vec_reg [6];
  logic [11:0] extent_w, extent_h;

  vpp_in_t  vertex_q [$];     // vertices waiting to be driven
  vpp_out_t screen_q [$];     // predicted screen points, oldest first
  int       errors = 0;
  int       idle_gap = 0;
  bit       calm = 1'b0;      // no idling in the last part of the run
  int       quiet_cycles = 0;

  function automatic longint sx16(logic [15:0] raw);
    return longint'($signed(raw));
  endfunction

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // floor of the square root, digit by digit
  function automatic longint root_floor(longint s);
    longint r;
    longint bitv;
    r = 0;
    bitv = longint'(1) <<< 62;
    while (bitv > s) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (s >= r + bitv) begin
        s = s - (r + bitv);
        r = (r >>> 1) + bitv;
      end else begin
        r = r >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return r;
  endfunction

  function automatic longint scale_screen(longint p, longint off, logic [11:0] ext,
                                          longint scr);
    longint w;
    longint v;
    w = (ext == 0) ? 1 : longint'(ext);
    v = 2 * (p - off * 256) + w * 256;
    return clampl((v * scr) / (w * 512), -32768, 32767);
  endfunction

  function automatic vpp_out_t project_vertex(vpp_in_t vin);
    longint e[3], n[3], c[3], a[3], b[3], d[3], v[3], ab[3], ad[3], pa[3];
    longint num, den, dotx, doty, sab, sad, off, px, py;
    vpp_out_t r;
    num = 0; den = 0; dotx = 0; doty = 0; sab = 0; sad = 0;
    for (int k = 0; k < 3; k++) begin
      e[k] = sx16(vec_reg[REG_EYE][16*k +: 16]);
      n[k] = sx16(vec_reg[REG_NORMAL][16*k +: 16]);
      c[k] = sx16(vec_reg[REG_CENTROID][16*k +: 16]);
      a[k] = sx16(vec_reg[REG_CORNER_A][16*k +: 16]);
      b[k] = sx16(vec_reg[REG_CORNER_B][16*k +: 16]);
      d[k] = sx16(vec_reg[REG_CORNER_D][16*k +: 16]);
    end
    v[0] = sx16(vin.vertex_x);
    v[1] = sx16(vin.vertex_y);
    v[2] = sx16(vin.vertex_z);
    for (int k = 0; k < 3; k++) begin
      num += n[k] * (e[k] - c[k]);
      den += n[k] * (e[k] - v[k]);
      ab[k] = b[k] - a[k];
      ad[k] = d[k] - a[k];
      sab += ab[k] * ab[k];
      sad += ad[k] * ad[k];
    end
    r = '0;
    r.result_tag = vin.vertex_tag;
    // ray parallel to the plane or collapsed basis: no hit
    if (den != 0 && sab != 0 && sad != 0) begin
      for (int k = 0; k < 3; k++) begin
        off = (num * (v[k] - e[k])) / den;
        pa[k] = clampl(e[k] + off - a[k], -(longint'(1) <<< 31),
                       (longint'(1) <<< 31) - 1);
        dotx += pa[k] * ab[k];
        doty += pa[k] * ad[k];
      end
      px = clampl(dotx / root_floor(sab), -(longint'(1) <<< 40), longint'(1) <<< 40);
      py = clampl(doty / root_floor(sad), -(longint'(1) <<< 40), longint'(1) <<< 40);
      r.screen_x = 16'(scale_screen(px, OFFSET_X, extent_w, SCREEN_WIDTH));
      r.screen_y = 16'(scale_screen(py, OFFSET_Y, extent_h, SCREEN_HEIGHT));
      r.ok = 1'b1;
    end
    return r;
  endfunction

  // driver: issues queued vertices, with random idle bursts
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        screen_q.push_back(project_vertex(item_i));
      end
      if (start_i && busy_o) begin
        // transfer still pending, hold the item
      end else if (idle_gap > 0) begin
        idle_gap--;
        start_i <= 1'b0;
      end else if (vertex_q.size() > 0) begin
        if (!calm && $urandom_range(0, 11) == 0) begin
          idle_gap = $urandom_range(0, 13);
          start_i <= 1'b0;
        end else begin
          item_i <= vertex_q.pop_front();
          start_i <= 1'b1;
        end
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor: every strobe must match the oldest prediction
  always @(posedge clk_i) begin
    vpp_out_t want;
    if (rst_ni && result_valid_o) begin
      if (screen_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, result_o);
      end else begin
        want = screen_q.pop_front();
        if (result_o.screen_x !== want.screen_x) begin
          errors++;
          $display("%0t: screen_x expected %0d actual %0d", $time,
                   want.screen_x, result_o.screen_x);
        end
        if (result_o.screen_y !== want.screen_y) begin
          errors++;
          $display("%0t: screen_y expected %0d actual %0d", $time,
                   want.screen_y, result_o.screen_y);
        end
        if (result_o.result_tag !== want.result_tag) begin
          errors++;
          $display("%0t: result_tag expected %0d actual %0d", $time,
                   want.result_tag, result_o.result_tag);
        end
        if (result_o.ok !== want.ok) begin
          errors++;
          $display("%0t: ok expected %0b actual %0b", $time, want.ok, result_o.ok);
        end
      end
    end
  end

  // watchdog: cycles with no transfer on either side
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // register write, mirrored into the predictor's copy
  task automatic cfg_write(cfg_reg_e idx, logic [47:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    if (idx == REG_WIDTH) extent_w = data[11:0];
    else if (idx == REG_HEIGHT) extent_h = data[11:0];
    else vec_reg[idx] = data;
  endtask

  task automatic cfg_done();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // sender pauses until every prediction has been met
  task automatic drain();
    while (vertex_q.size() != 0 || start_i || screen_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [47:0] pack3(int x, int y, int z);
    return {16'(z), 16'(y), 16'(x)};
  endfunction

  // q8.8 vector, mostly near the origin, sometimes anywhere
  function automatic logic [47:0] rand_vec(int span);
    logic [47:0] r;
    for (int k = 0; k < 3; k++) begin
      if ($urandom_range(0, 5) == 0) r[16*k +: 16] = 16'($urandom);
      else r[16*k +: 16] = 16'($urandom_range(0, 2 * span) - span);
    end
    return r;
  endfunction

  function automatic vpp_in_t mk_vertex(int x, int y, int z, int tag);
    vpp_in_t v;
    v.vertex_x = 16'(x);
    v.vertex_y = 16'(y);
    v.vertex_z = 16'(z);
    v.vertex_tag = 3'(tag);
    return v;
  endfunction

  task automatic push_random(int count, int span);
    vpp_in_t v;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        v = vpp_in_t'($urandom_range(0, 7) | ({$urandom, $urandom} << 3));
      end else begin
        v = mk_vertex($urandom_range(0, 2 * span) - span,
                      $urandom_range(0, 2 * span) - span,
                      $urandom_range(0, 2 * span) - span, $urandom_range(0, 7));
      end
      vertex_q.push_back(v);
    end
  endtask

  // a sensible viewing setup: eye behind, plane across z, square corners
  task automatic setup_view();
    int s;
    s = $urandom_range(64, 4096);
    cfg_write(REG_EYE, pack3($urandom_range(0, 512) - 256, $urandom_range(0, 512) - 256,
                             -$urandom_range(256, 8192)));
    cfg_write(REG_NORMAL, rand_vec(512));
    cfg_write(REG_CENTROID, rand_vec(2048));
    cfg_write(REG_CORNER_A, pack3(-s, -s, 0));
    cfg_write(REG_CORNER_B, pack3(s, -s, 0));
    cfg_write(REG_CORNER_D, pack3(-s, s, 0));
    cfg_write(REG_WIDTH, 48'($urandom_range(1, 4095)));
    cfg_write(REG_HEIGHT, 48'($urandom_range(1, 4095)));
    cfg_done();
  endtask

  initial begin
    // power-on register values
    vec_reg[REG_EYE] = '0;
    vec_reg[REG_NORMAL] = 48'h0100_0000_0000;
    vec_reg[REG_CENTROID] = '0;
    vec_reg[REG_CORNER_A] = '0;
    vec_reg[REG_CORNER_B] = 48'h0000_0000_0100;
    vec_reg[REG_CORNER_D] = 48'h0000_0100_0000;
    extent_w = 12'd80;
    extent_h = 12'd60;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes under the power-on setup; zero z is parallel
    vertex_q.push_back(mk_vertex(0, 0, 0, 0));
    vertex_q.push_back(mk_vertex(32767, 32767, 32767, 7));
    vertex_q.push_back(mk_vertex(-32768, -32768, -32768, 5));
    vertex_q.push_back(mk_vertex(-32768, 32767, 256, 2));
    vertex_q.push_back(mk_vertex(256, 256, -256, 1));
    vertex_q.push_back(mk_vertex(100, -100, 1, 6));
    vertex_q.push_back(mk_vertex(0, 0, -1, 3));
    vertex_q.push_back(mk_vertex(32767, -32768, 0, 4));
    drain();

    // eye off the origin, plane at z = 2.0, wide screen extents
    cfg_write(REG_EYE, pack3(0, 0, -1024));
    cfg_write(REG_CENTROID, pack3(0, 0, 512));
    cfg_write(REG_CORNER_A, pack3(-2560, -2560, 512));
    cfg_write(REG_CORNER_B, pack3(2560, -2560, 512));
    cfg_write(REG_CORNER_D, pack3(-2560, 2560, 512));
    cfg_write(REG_WIDTH, 48'd4095);
    cfg_write(REG_HEIGHT, 48'd1);
    cfg_done();
    vertex_q.push_back(mk_vertex(0, 0, -1024, 0));      // vertex on the eye plane
    vertex_q.push_back(mk_vertex(512, 512, 0, 1));
    vertex_q.push_back(mk_vertex(-32768, 32767, 32767, 2));
    vertex_q.push_back(mk_vertex(1, 1, -1023, 3));      // far hit, clamps
    vertex_q.push_back(mk_vertex(32767, 32767, -32768, 7));
    drain();

    // collapsed basis and zero extents
    cfg_write(REG_CORNER_B, pack3(-2560, -2560, 512));
    cfg_write(REG_WIDTH, 48'd0);
    cfg_write(REG_HEIGHT, 48'd0);
    cfg_done();
    vertex_q.push_back(mk_vertex(512, 512, 0, 4));
    vertex_q.push_back(mk_vertex(-512, 0, 256, 5));
    drain();
    cfg_write(REG_CORNER_B, pack3(2560, -2560, 512));
    cfg_write(REG_CORNER_D, pack3(-2560, -2560, 512));
    cfg_done();
    vertex_q.push_back(mk_vertex(512, 512, 0, 6));
    vertex_q.push_back(mk_vertex(0, 0, 0, 7));
    drain();

    // all-ones and most-negative registers
    for (int i = 0; i < 6; i++) cfg_write(cfg_reg_e'(i), (i % 2) ? '1 : 48'h8000_8000_8000);
    cfg_write(REG_WIDTH, 48'hFFF);
    cfg_write(REG_HEIGHT, 48'h001);
    cfg_done();
    push_random(20, 32768);
    drain();

    // random part: mostly plausible views, some wild setups
    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 6) calm = 1'b1;
      if (ph % 3 == 2) begin
        for (int i = 0; i < 6; i++) cfg_write(cfg_reg_e'(i), rand_vec(8192));
        cfg_write(REG_WIDTH, 48'($urandom_range(0, 4095)));
        cfg_write(REG_HEIGHT, 48'($urandom_range(0, 4095)));
        cfg_done();
      end else begin
        setup_view();
      end
      push_random(240, (ph % 2) ? 1024 : 16384);
      drain();
    end

    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
